// ===== rtl/core/bfpa_pkg.sv =====
// Package with command and status codes and the transaction types of the allocator.
package bfpa_pkg;

  // Command codes
  localparam logic [1:0] CMD_DEFINE  = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_TOO_BIG   = 3'd1;
  localparam logic [2:0] ST_MEM_FULL  = 3'd2;
  localparam logic [2:0] ST_RELEASED  = 3'd3;
  localparam logic [2:0] ST_NOT_OWNED = 3'd4;
  localparam logic [2:0] ST_DEFINED   = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  part_index;
    logic [15:0] base_addr;
    logic [15:0] req_size;
    logic [3:0]  owner_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  sel_index;
    logic [15:0] sel_base;
    logic [15:0] sel_size;
  } rsp_t;

endpackage

// ===== rtl/core/best_fit_partition_allocator_core.sv =====
// Top level of the best-fit fixed partition allocator.
//
//   Channel  | Direction | Handshake                 | Payload
//   ---------+-----------+---------------------------+---------------
//   command  | in        | start high while busy low | req_i (req_t)
//   result   | out       | rsp_valid_o, one cycle    | rsp_o (rsp_t)
//
// Define and unused commands pass through S_DONE to the registered result.
// Allocate and release walk the partition memory one entry per cycle through its
// single read port; a release that finds its owner ends the walk early.
// busy falls in the cycle the result is shown.
// Reset clears every partition to base 0, size 0 and free at once through
// per-entry valid bits; no clearing pass. The receiver cannot stall the block.
module best_fit_partition_allocator_core import bfpa_pkg::*; #(
  parameter int NUM_PARTITIONS = 16,
  parameter int ADDR_BITS      = 16,
  parameter int OWNER_BITS     = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  base;
    logic [ADDR_BITS-1:0]  size;
    logic [OWNER_BITS-1:0] owner;
  } slot_t;

  // Partition memory and per-entry flags
  slot_t mem_q [NUM_PARTITIONS];
  slot_t mem_rdata_q;
  logic [NUM_PARTITIONS-1:0] valid_q, valid_d;
  logic [NUM_PARTITIONS-1:0] busy_q, busy_d;

  logic [1:0] state_q, state_d;

  // Latched command
  logic [1:0]            cmd_q, cmd_d;
  logic [3:0]            part_q, part_d;
  logic                  in_range_q, in_range_d;
  logic [ADDR_BITS-1:0]  base_q, base_d;
  logic [ADDR_BITS-1:0]  want_q, want_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;

  // Scan control
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_more_q, rd_more_d;
  logic             dv_q, dv_d;
  logic [IDX_W-1:0] d_idx_q, d_idx_d;

  // Search trackers
  logic [ADDR_BITS-1:0] largest_q, largest_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_idx_q, pick_idx_d;
  logic [ADDR_BITS-1:0] pick_base_q, pick_base_d;
  logic [ADDR_BITS-1:0] pick_size_q, pick_size_d;

  // Result register
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  // Memory port controls
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;

  // Field conversions
  logic                  accept;
  logic [31:0]           req_size_ext, base_addr_ext;
  logic [7:0]            owner_ext, part_ext, pick_ext;
  logic [31:0]           pick_base_ext, pick_size_ext;
  logic [IDX_W-1:0]      part_widx;

  // Evaluated entry
  logic [ADDR_BITS-1:0]  e_size, e_base;
  logic [OWNER_BITS-1:0] e_owner;
  logic                  e_busy, e_fit, e_match;

  assign accept        = start && !busy;
  assign req_size_ext  = 32'(req_i.req_size);
  assign base_addr_ext = 32'(req_i.base_addr);
  assign owner_ext     = 8'(req_i.owner_id);
  assign part_ext      = 8'(part_q);
  assign part_widx     = part_ext[IDX_W-1:0];
  assign pick_ext      = 8'(pick_idx_q);
  assign pick_base_ext = 32'(pick_base_q);
  assign pick_size_ext = 32'(pick_size_q);

  // Entry in the data stage; an undefined entry reads as zero
  assign e_size  = valid_q[d_idx_q] ? mem_rdata_q.size  : '0;
  assign e_base  = valid_q[d_idx_q] ? mem_rdata_q.base  : '0;
  assign e_owner = valid_q[d_idx_q] ? mem_rdata_q.owner : '0;
  assign e_busy  = busy_q[d_idx_q];
  assign e_fit   = !e_busy && (e_size >= want_q);
  assign e_match = e_busy && (e_owner == owner_q);

  assign mem_re = (state_q == S_SCAN) && rd_more_q;

  // Sequence the transaction: latch, scan, decide and write back
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    part_d      = part_q;
    in_range_d  = in_range_q;
    base_d      = base_q;
    want_d      = want_q;
    owner_d     = owner_q;
    rd_idx_d    = rd_idx_q;
    rd_more_d   = rd_more_q;
    dv_d        = 1'b0;
    d_idx_d     = d_idx_q;
    largest_d   = largest_q;
    found_d     = found_q;
    pick_idx_d  = pick_idx_q;
    pick_base_d = pick_base_q;
    pick_size_d = pick_size_q;
    valid_d     = valid_q;
    busy_d      = busy_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = pick_idx_q;
    mem_wdata   = '{base: pick_base_q, size: pick_size_q, owner: owner_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d       = req_i.cmd;
          part_d      = req_i.part_index;
          in_range_d  = 32'(req_i.part_index) < 32'(NUM_PARTITIONS);
          base_d      = base_addr_ext[ADDR_BITS-1:0];
          want_d      = req_size_ext[ADDR_BITS-1:0];
          owner_d     = owner_ext[OWNER_BITS-1:0];
          rd_idx_d    = '0;
          rd_more_d   = 1'b1;
          largest_d   = '0;
          found_d     = 1'b0;
          pick_idx_d  = '0;
          pick_base_d = '0;
          pick_size_d = '0;
          if (req_i.cmd == CMD_ALLOC || req_i.cmd == CMD_RELEASE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (rd_more_q) begin
          dv_d    = 1'b1;
          d_idx_d = rd_idx_q;
          if (rd_idx_q == LAST_IDX) begin
            rd_more_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // Evaluate the entry read last cycle
        if (dv_q) begin
          if (cmd_q == CMD_ALLOC) begin
            if (e_size > largest_q) begin
              largest_d = e_size;
            end
            if (e_fit && (!found_q || e_size < pick_size_q)) begin
              found_d     = 1'b1;
              pick_idx_d  = d_idx_q;
              pick_base_d = e_base;
              pick_size_d = e_size;
            end
            if (d_idx_q == LAST_IDX) begin
              state_d = S_DONE;
            end
          end else begin
            if (e_match) begin
              found_d     = 1'b1;
              pick_idx_d  = d_idx_q;
              pick_base_d = e_base;
              pick_size_d = e_size;
              state_d     = S_DONE;
              dv_d        = 1'b0;
            end else if (d_idx_q == LAST_IDX) begin
              state_d = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        state_d     = S_IDLE;
        rsp_valid_d = 1'b1;
        rsp_d       = '{status: ST_NOT_OWNED, sel_index: 4'd0, sel_base: 16'd0,
                        sel_size: 16'd0};
        case (cmd_q)
          CMD_DEFINE: begin
            rsp_d.status    = ST_DEFINED;
            rsp_d.sel_index = part_q;
            if (in_range_q) begin
              mem_we             = 1'b1;
              mem_waddr          = part_widx;
              mem_wdata          = '{base: base_q, size: want_q, owner: '0};
              valid_d[part_widx] = 1'b1;
              busy_d[part_widx]  = 1'b0;
            end
          end
          CMD_ALLOC: begin
            if (want_q > largest_q) begin
              rsp_d.status = ST_TOO_BIG;
            end else if (!found_q) begin
              rsp_d.status = ST_MEM_FULL;
            end else begin
              mem_we              = 1'b1;
              valid_d[pick_idx_q] = 1'b1;
              busy_d[pick_idx_q]  = 1'b1;
              rsp_d.status        = ST_ALLOCATED;
              rsp_d.sel_index     = pick_ext[3:0];
              rsp_d.sel_base      = pick_base_ext[15:0];
              rsp_d.sel_size      = pick_size_ext[15:0];
            end
          end
          CMD_RELEASE: begin
            if (found_q) begin
              busy_d[pick_idx_q] = 1'b0;
              rsp_d.status       = ST_RELEASED;
              rsp_d.sel_index    = pick_ext[3:0];
              rsp_d.sel_base     = pick_base_ext[15:0];
              rsp_d.sel_size     = pick_size_ext[15:0];
            end
          end
          default: begin
            rsp_d.status = ST_NOT_OWNED;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the partition memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[rd_idx_q];
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      busy_q      <= '0;
      rd_more_q   <= 1'b0;
      dv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      busy_q      <= busy_d;
      rd_more_q   <= rd_more_d;
      dv_q        <= dv_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Hold payload and tracker registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    part_q      <= part_d;
    in_range_q  <= in_range_d;
    base_q      <= base_d;
    want_q      <= want_d;
    owner_q     <= owner_d;
    rd_idx_q    <= rd_idx_d;
    d_idx_q     <= d_idx_d;
    largest_q   <= largest_d;
    found_q     <= found_d;
    pick_idx_q  <= pick_idx_d;
    pick_base_q <= pick_base_d;
    pick_size_q <= pick_size_d;
    rsp_q       <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/core/bfpa_checker.sv =====
// Port-level checker for the allocator core and its bind.
module bfpa_checker import bfpa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // An accepted transaction keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // busy drops exactly when the result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> rsp_valid_o)
    else $error("busy dropped without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result shown while busy");

  // No two results back to back: one result per transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe held for two cycles");

  // Error answers carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ST_TOO_BIG || rsp_o.status == ST_MEM_FULL ||
                     rsp_o.status == ST_NOT_OWNED))
    |-> (rsp_o.sel_index == 4'd0 && rsp_o.sel_base == 16'd0 && rsp_o.sel_size == 16'd0))
    else $error("error result with nonzero fields");

endmodule

bind best_fit_partition_allocator_core bfpa_checker u_bfpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
